// ===== hw/rtl/ovc_pkg.sv =====
// Package: types, constants and per-stage arithmetic of the occupancy velocity colorizer.
`timescale 1ns / 1ps
package ovc_pkg;

  // Pipeline depth and stage positions
  localparam int NumStages   = 22;
  localparam int StNum       = 1;
  localparam int StSearch0   = 2;
  localparam int StSearchEnd = 18;
  localparam int CordicSteps = 16;
  localparam int StAngle     = 19;
  localparam int StProd      = 20;
  localparam int StColor     = 21;

  // Angles in units of 30 deg / 65536
  localparam logic [19:0] HalfTurn    = 20'd393216;
  localparam logic [19:0] QuarterTurn = 20'd196608;
  localparam logic [19:0] FullTurn    = 20'd786432;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_OCC_THR = 2'd0,
    CFG_DYN_THR = 2'd1,
    CFG_MAX_VEL = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] OccThrReset = 16'd32768;
  localparam logic [23:0] DynThrReset = 24'd1024;
  localparam logic [14:0] MaxVelReset = 15'd2560;

  // Everything one item carries down the pipeline
  typedef struct packed {
    logic               occ_ok;
    logic [7:0]         grey;
    logic               dyn;
    logic               det_pos;
    logic [15:0]        a;
    logic [15:0]        b;
    logic signed [15:0] c;
    logic [30:0]        sqx;
    logic [30:0]        sqy;
    logic signed [31:0] pxy;
    logic signed [33:0] det;
    logic signed [49:0] num;
    logic [55:0]        tdet;
    logic [31:0]        speed;
    logic               negx;
    logic               negy;
    logic [16:0]        ax;
    logic [16:0]        ay;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [20:0] cz;
    logic [65:0]        p2;
    logic [47:0]        q;
    logic [16:0]        v;
    logic               done;
    logic [2:0]         sector;
    logic [15:0]        f;
    logic [7:0]         full;
    logic [32:0]        vf;
    logic [32:0]        vg;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pipe_t;

  // Arctangent table for the vectoring steps
  function automatic logic [16:0] cordic_angle(input int i);
    logic [16:0] r;
    r = '0;
    unique case (i)
      0:  r = 17'd98304;
      1:  r = 17'd58032;
      2:  r = 17'd30663;
      3:  r = 17'd15565;
      4:  r = 17'd7813;
      5:  r = 17'd3910;
      6:  r = 17'd1956;
      7:  r = 17'd978;
      8:  r = 17'd489;
      9:  r = 17'd244;
      10: r = 17'd122;
      11: r = 17'd61;
      12: r = 17'd31;
      13: r = 17'd15;
      14: r = 17'd8;
      15: r = 17'd4;
      default: r = '0;
    endcase
    return r;
  endfunction

  // First stage: unpack the cell, square terms, determinant, occupancy
  function automatic pipe_t front_step(input logic [111:0] d, input logic [15:0] occ_thr);
    pipe_t              n;
    logic [15:0]        fm;
    logic [15:0]        om;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [17:0]        occ2;
    logic [17:0]        gval;
    logic [24:0]        gsum;
    logic [31:0]        ab;
    logic signed [31:0] cc;
    n    = '0;
    fm   = d[15:0];
    om   = d[31:16];
    vx   = d[47:32];
    vy   = d[63:48];
    n.a  = d[79:64];
    n.b  = d[95:80];
    n.c  = d[111:96];
    occ2 = 18'd65536 + 18'(om) - 18'(fm);
    n.occ_ok = (occ2 >= {1'b0, occ_thr, 1'b0});
    gval = 18'd131072 - occ2;
    gsum = 25'(gval) * 25'd255 + 25'd65536;
    n.grey = gsum[24:17];
    ab    = 32'(n.a) * 32'(n.b);
    cc    = 32'(n.c) * 32'(n.c);
    n.det = $signed({2'b0, ab}) - 34'(cc);
    n.sqx = 31'(32'(vx) * 32'(vx));
    n.sqy = 31'(32'(vy) * 32'(vy));
    n.pxy = 32'(vx) * 32'(vy);
    n.negx = vx[15];
    n.negy = vy[15];
    n.ax = vx[15] ? 17'(-18'(vx)) : 17'(vx);
    n.ay = vy[15] ? 17'(-18'(vy)) : 17'(vy);
    return n;
  endfunction

  // Later stages, selected by the stage position k
  function automatic pipe_t stage_step(input pipe_t p, input int k, input logic [23:0] dyn_thr,
                                       input logic [29:0] m2);
    pipe_t              n;
    logic signed [49:0] t1;
    logic signed [49:0] t2;
    logic signed [49:0] t3;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic [65:0]        cand;
    logic [65:0]        target;
    logic [19:0]        alpha;
    logic [19:0]        theta;
    logic [3:0]         hi;
    logic [23:0]        fsum;
    logic [40:0]        rsum;
    logic [40:0]        lsum;
    int                 bitk;
    int                 i;
    n = p;
    if (k == StNum) begin
      // Mahalanobis numerator and scaled determinant
      t1 = $signed(50'(p.b) * 50'(p.sqx));
      t2 = 50'(p.c) * 50'(p.pxy);
      t3 = $signed(50'(p.a) * 50'(p.sqy));
      n.num     = t1 - (t2 <<< 1) + t3;
      n.det_pos = (p.det > 34'sd0);
      n.tdet    = 56'(dyn_thr) * 56'(p.det[31:0]);
      n.speed   = 32'(p.sqx) + 32'(p.sqy);
      n.cx      = $signed({3'b0, p.ax, 16'b0});
      n.cy      = $signed({3'b0, p.ay, 16'b0});
      n.cz      = '0;
      n.p2      = '0;
      n.q       = '0;
      n.v       = '0;
      n.done    = 1'b0;
    end else if (k >= StSearch0 && k <= StSearchEnd) begin
      if (k == StSearch0) begin
        n.dyn = p.occ_ok && p.det_pos &&
                ($signed({{8{p.num[49]}}, p.num}) >= $signed({2'b0, p.tdet}));
      end
      // One vectoring step
      if (k < StSearch0 + CordicSteps) begin
        i  = k - StSearch0;
        dx = p.cy >>> i;
        dy = p.cx >>> i;
        if (!p.cy[35]) begin
          n.cx = p.cx + dx;
          n.cy = p.cy - dy;
          n.cz = p.cz + $signed({4'b0, cordic_angle(i)});
        end else begin
          n.cx = p.cx - dx;
          n.cy = p.cy + dy;
          n.cz = p.cz - $signed({4'b0, cordic_angle(i)});
        end
      end
      // One bit of the brightness search, most significant first
      bitk   = StSearchEnd - k;
      target = 66'({p.speed, 32'b0});
      cand   = p.p2 + (66'(p.q) << (bitk + 1)) + (66'(m2) << (2 * bitk));
      if (!p.done && cand <= target) begin
        n.p2 = cand;
        n.q  = p.q + 48'(48'(m2) << bitk);
        n.v  = p.v | 17'(17'd1 << bitk);
        if (bitk == 16) n.done = 1'b1;
      end
    end else if (k == StAngle) begin
      // Clamp, handle the axes, mirror into the quadrant
      priority if (p.ay == '0) alpha = '0;
      else if (p.ax == '0) alpha = QuarterTurn;
      else if (p.cz[20]) alpha = '0;
      else if (20'(p.cz) > QuarterTurn) alpha = QuarterTurn;
      else alpha = 20'(p.cz);
      unique case ({p.negx, p.negy})
        2'b00:   theta = alpha + HalfTurn;
        2'b10:   theta = FullTurn - alpha;
        2'b11:   theta = alpha;
        default: theta = HalfTurn - alpha;
      endcase
      hi = theta[19:16];
      priority if (hi >= 4'd12) hi = hi - 4'd12;
      else if (hi >= 4'd6) hi = hi - 4'd6;
      n.sector = hi[2:0];
      n.f      = theta[15:0];
    end else if (k == StProd) begin
      n.vf   = 33'(p.v) * 33'(p.f);
      n.vg   = 33'(34'(p.v) * (34'd65536 - 34'(p.f)));
      fsum   = 24'(p.v) * 24'd255 + 24'd32768;
      n.full = fsum[23:16];
    end else if (k == StColor) begin
      rsum = 41'(p.vf) * 41'd255 + 41'h0080000000;
      lsum = 41'(p.vg) * 41'd255 + 41'h0080000000;
      if (!p.dyn) begin
        n.red   = p.grey;
        n.green = p.grey;
        n.blue  = p.grey;
      end else begin
        unique case (p.sector)
          3'd0: begin n.red = p.full;      n.green = rsum[39:32]; n.blue = '0;          end
          3'd1: begin n.red = lsum[39:32]; n.green = p.full;      n.blue = '0;          end
          3'd2: begin n.red = '0;          n.green = p.full;      n.blue = rsum[39:32]; end
          3'd3: begin n.red = '0;          n.green = lsum[39:32]; n.blue = p.full;      end
          3'd4: begin n.red = rsum[39:32]; n.green = '0;          n.blue = p.full;      end
          default: begin n.red = p.full;   n.green = '0;          n.blue = lsum[39:32]; end
        endcase
      end
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/occupancy_velocity_colorizer.sv =====
// Top level: streaming occupancy grid cell to RGB pixel renderer.
`timescale 1ns / 1ps
// One grid cell enters on the s_axis channel per item and one RGB pixel leaves on m_axis.
// Cells are free and occupied mass, mean velocity and velocity covariance; the pixel is a
// full-saturation hue from the velocity direction for dynamic cells, grey otherwise.
// Configuration: cfg_valid_i/cfg_addr_i/cfg_data_i write occupancy threshold (0),
// dynamic threshold (1) and max velocity (2); cfg_ready_o is always high, other
// indexes are ignored. Write it only while no item is in flight.
// Throughput: one item per cycle while the receiver is ready. The depth is set by sixteen
// vectoring steps for the direction, running beside a seventeen-step bit search for
// brightness, plus the Mahalanobis products in front and the color products behind.
// Each stage holds a valid bit and moves when the stage after it is empty or moving,
// so a stalled receiver fills the empty stages first; s_axis_tready falls only when
// every stage holds an item. Nothing is dropped or repeated across a stall.
// Reset clears all valid bits and loads the register defaults
// (32768, 1024, 2560).
module occupancy_velocity_colorizer
  import ovc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // free_evid, occupied_mass, vel_x, vel_y, var_x, var_y, cov_xy (from bit 0 up)
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // red, green, blue (from bit 0 up)
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [23:0]  cfg_data_i
);

  logic [15:0] occ_thr_q;
  logic [23:0] dyn_thr_q;
  logic [14:0] max_vel_q;
  logic [29:0] m2_q;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;
  pipe_t                pipe_q [NumStages];
  pipe_t                pipe_d [NumStages];

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_thr_q <= OccThrReset;
      dyn_thr_q <= DynThrReset;
      max_vel_q <= MaxVelReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_OCC_THR: occ_thr_q <= cfg_data_i[15:0];
        CFG_DYN_THR: dyn_thr_q <= cfg_data_i;
        CFG_MAX_VEL: max_vel_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Hold the squared max velocity for the brightness search
  always_ff @(posedge clk_i) begin
    m2_q <= 30'(max_vel_q) * 30'(max_vel_q);
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage arithmetic
  always_comb begin
    pipe_d[0] = front_step(s_axis_tdata, occ_thr_q);
    for (int k = 1; k < NumStages; k++) begin
      pipe_d[k] = stage_step(pipe_q[k-1], k, dyn_thr_q, m2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) pipe_q[k] <= pipe_d[k];
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {pipe_q[NumStages-1].blue, pipe_q[NumStages-1].green,
                          pipe_q[NumStages-1].red};

  // An empty output stage means the whole pipeline can move
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NumStages-1] |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // Brightness never exceeds one
  a_value_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StAngle] |-> pipe_q[StAngle].v <= 17'd65536)
    else $error("brightness above full scale");

  // Non-dynamic cells leave as grey
  a_grey_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !pipe_q[NumStages-1].dyn) |->
      (m_axis_tdata[7:0] == m_axis_tdata[15:8] && m_axis_tdata[15:8] == m_axis_tdata[23:16]))
    else $error("non-dynamic cell not grey");

endmodule
